[hw/rtl/crbu_pkg.sv]
// crbu_pkg: shared types and constants for the cr logic and branch condition unit
// no dependencies; used by crbu_exec, cr_logic_and_branch_condition_unit, crbu_result_checker and tb_top
`default_nettype none

package crbu_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned MODE_W = 4;
	localparam logic [XLEN-1:0] ADDR_ALIGN_MASK = 32'hffff_fffc;
	localparam logic [XLEN-1:0] LINK_STEP = 32'd4;

	typedef enum logic [MODE_W-1:0] {
		MODE_CROR     = 4'd0,
		MODE_CRNOR    = 4'd1,
		MODE_CRXOR    = 4'd2,
		MODE_MCRF     = 4'd3,
		MODE_BCLR     = 4'd4,
		MODE_BCCTR    = 4'd5,
		MODE_LOAD_CR  = 4'd6,
		MODE_LOAD_CTR = 4'd7,
		MODE_LOAD_LR  = 4'd8
	} mode_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [XLEN-1:0]   insn_word;
		logic [XLEN-1:0]   insn_address;
		logic [XLEN-1:0]   load_value;
	} item_t;

	typedef struct packed {
		logic [XLEN-1:0] cr;
		logic [XLEN-1:0] ctr;
		logic [XLEN-1:0] lr;
	} regs_t;

	typedef struct packed {
		logic            taken;
		logic [XLEN-1:0] target;
	} branch_t;

endpackage

`default_nettype wire

[hw/rtl/crbu_exec.sv]
// crbu_exec: single-pass execute logic for cr logical, mcrf, bclr, bcctr and loads
// depends on crbu_pkg
`default_nettype none

module crbu_exec (
	input  wire crbu_pkg::item_t   item,
	input  wire crbu_pkg::regs_t   regs_cur,
	output crbu_pkg::regs_t        regs_nxt,
	output crbu_pkg::branch_t      branch
);

	logic [4:0]  fd;
	logic [4:0]  fa;
	logic [4:0]  fb;
	logic        lk;
	logic        bit_a;
	logic        bit_b;
	logic [4:0]  pos_d;
	logic [3:0]  src_field;
	logic [31:0] ctr_dec;
	logic        ctr_ok;
	logic        cond_ok;

	assign fd = item.insn_word[25:21];
	assign fa = item.insn_word[20:16];
	assign fb = item.insn_word[15:11];
	assign lk = item.insn_word[0];

	assign bit_a = regs_cur.cr[5'd31 - fa];
	assign bit_b = regs_cur.cr[5'd31 - fb];
	assign pos_d = 5'd31 - fd;
	assign src_field = regs_cur.cr[{~fa[4:2], 2'b00} +: 4];

	assign ctr_dec = fd[2] ? regs_cur.ctr : regs_cur.ctr - 32'd1;
	assign ctr_ok = fd[2] | ((ctr_dec != 32'd0) ^ fd[1]);
	assign cond_ok = fd[4] | (bit_a == fd[3]);

	always_comb begin
		regs_nxt = regs_cur;
		branch = '0;
		unique case (crbu_pkg::mode_t'(item.mode))
			crbu_pkg::MODE_CROR: begin
				regs_nxt.cr[pos_d] = bit_a | bit_b;
			end
			crbu_pkg::MODE_CRNOR: begin
				regs_nxt.cr[pos_d] = ~(bit_a | bit_b);
			end
			crbu_pkg::MODE_CRXOR: begin
				regs_nxt.cr[pos_d] = bit_a ^ bit_b;
			end
			crbu_pkg::MODE_MCRF: begin
				regs_nxt.cr[{~fd[4:2], 2'b00} +: 4] = src_field;
			end
			crbu_pkg::MODE_BCLR: begin
				regs_nxt.ctr = ctr_dec;
				if (lk) begin
					regs_nxt.lr = item.insn_address + crbu_pkg::LINK_STEP;
				end
				if (ctr_ok && cond_ok) begin
					branch.taken = 1'b1;
					branch.target = regs_cur.lr & crbu_pkg::ADDR_ALIGN_MASK;
				end
			end
			crbu_pkg::MODE_BCCTR: begin
				if (lk) begin
					regs_nxt.lr = item.insn_address + crbu_pkg::LINK_STEP;
				end
				if (cond_ok) begin
					branch.taken = 1'b1;
					branch.target = regs_cur.ctr & crbu_pkg::ADDR_ALIGN_MASK;
				end
			end
			crbu_pkg::MODE_LOAD_CR: begin
				regs_nxt.cr = item.load_value;
			end
			crbu_pkg::MODE_LOAD_CTR: begin
				regs_nxt.ctr = item.load_value;
			end
			crbu_pkg::MODE_LOAD_LR: begin
				regs_nxt.lr = item.load_value;
			end
			default: begin
				regs_nxt = regs_cur;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/cr_logic_and_branch_condition_unit.sv]
// Condition register logic and branch condition unit. Holds CR, CTR and LR (all zero
// after reset) and executes one operation per transfer: cror, crnor, crxor, mcrf, bclr,
// bcctr and direct loads of each register. Every transfer yields one result carrying the
// taken flag, the aligned target (zero when not taken) and the three registers after the
// operation. An item is registered on input, executed in one combinational pass against
// the architected registers and written to the result register, so the unit sustains one
// transfer per cycle while the output is not stalled; the result thus passes through the
// input register and the result register before it is offered. A new item is taken while
// a finished result waits on a stalled output.
// depends on crbu_pkg and crbu_exec
`default_nettype none

module cr_logic_and_branch_condition_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire [3:0]  mode,
	input  wire [31:0] insn_word,
	input  wire [31:0] insn_address,
	input  wire [31:0] load_value,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       taken,
	output logic [31:0] target,
	output logic [31:0] cond_reg,
	output logic [31:0] count_reg,
	output logic [31:0] link_reg
);

	logic              valid_s1;
	crbu_pkg::item_t   item_s1;
	logic              valid_s2;
	crbu_pkg::branch_t branch_s2;
	crbu_pkg::regs_t   regs_s2;
	crbu_pkg::regs_t   arch_q;
	crbu_pkg::regs_t   regs_nxt;
	crbu_pkg::branch_t branch_nxt;
	logic              adv_s1;
	logic              take_in;

	assign adv_s1 = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{mode: mode, insn_word: insn_word,
				insn_address: insn_address, load_value: load_value};
		end
	end

	crbu_exec u_exec (
		.item     (item_s1),
		.regs_cur (arch_q),
		.regs_nxt (regs_nxt),
		.branch   (branch_nxt)
	);

	// architected registers commit as the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				arch_q <= regs_nxt;
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			branch_s2 <= branch_nxt;
			regs_s2 <= regs_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign taken = branch_s2.taken;
	assign target = branch_s2.target;
	assign cond_reg = regs_s2.cr;
	assign count_reg = regs_s2.ctr;
	assign link_reg = regs_s2.lr;

	a_target_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (branch_s2.target[1:0] == 2'b00))
		else $error("result target not word aligned");

	a_not_taken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !branch_s2.taken) |-> (branch_s2.target == '0))
		else $error("target nonzero on a branch not taken");

	a_result_matches_arch: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (regs_s2 == arch_q) || valid_s1)
		else $error("result registers differ from committed state");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked item");

endmodule

`default_nettype wire

[verif/crbu_result_checker.sv]
// crbu_result_checker: watches both transfer channels of the cr logic and branch unit,
// predicts every result from its own copy of cr, ctr and lr and compares field by field
// depends on crbu_pkg for the operation codes and the address constants
`timescale 1ns / 1ps

module crbu_result_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        in_stall,
	input  wire [3:0]  mode,
	input  wire [31:0] insn_word,
	input  wire [31:0] insn_address,
	input  wire [31:0] load_value,
	input  wire        out_valid,
	input  wire        out_stall,
	input  wire        taken,
	input  wire [31:0] target,
	input  wire [31:0] cond_reg,
	input  wire [31:0] count_reg,
	input  wire [31:0] link_reg,
	output int         fail_count,
	output int         outstanding,
	output int         checked
);

	typedef struct packed {
		logic        taken;
		logic [31:0] target;
		logic [31:0] cr;
		logic [31:0] ctr;
		logic [31:0] lr;
	} outcome_t;

	logic [31:0] cr_copy;
	logic [31:0] ctr_copy;
	logic [31:0] lr_copy;
	outcome_t    outcome_q[$];

	function automatic logic cr_bit(logic [31:0] cr, logic [4:0] idx);
		return cr[31 - idx];
	endfunction

	task automatic apply_operation(input logic [3:0] op, input logic [31:0] insn,
			input logic [31:0] addr, input logic [31:0] lval, output outcome_t res);
		logic [4:0]  fd;
		logic [4:0]  fa;
		logic [4:0]  fb;
		logic [31:0] dsh;
		logic [31:0] ssh;
		logic [31:0] field;
		logic [31:0] dest;
		logic        ctr_ok;
		logic        cond_ok;
		fd = insn[25:21];
		fa = insn[20:16];
		fb = insn[15:11];
		res = '0;
		case (op)
			crbu_pkg::MODE_CROR:
				cr_copy[31 - fd] = cr_bit(cr_copy, fa) | cr_bit(cr_copy, fb);
			crbu_pkg::MODE_CRNOR:
				cr_copy[31 - fd] = ~(cr_bit(cr_copy, fa) | cr_bit(cr_copy, fb));
			crbu_pkg::MODE_CRXOR:
				cr_copy[31 - fd] = cr_bit(cr_copy, fa) ^ cr_bit(cr_copy, fb);
			crbu_pkg::MODE_MCRF: begin
				dsh = (7 - fd[4:2]) * 4;
				ssh = (7 - fa[4:2]) * 4;
				field = (cr_copy >> ssh) & 32'hf;
				cr_copy = (cr_copy & ~(32'hf << dsh)) | (field << dsh);
			end
			crbu_pkg::MODE_BCLR, crbu_pkg::MODE_BCCTR: begin
				cond_ok = fd[4] || (cr_bit(cr_copy, fa) == fd[3]);
				ctr_ok = 1'b1;
				if (op == crbu_pkg::MODE_BCLR) begin
					if (!fd[2])
						ctr_copy = ctr_copy - 32'd1;
					ctr_ok = fd[2] || ((ctr_copy != 32'd0) != fd[1]);
					dest = lr_copy & crbu_pkg::ADDR_ALIGN_MASK;
				end else begin
					dest = ctr_copy & crbu_pkg::ADDR_ALIGN_MASK;
				end
				if (insn[0])
					lr_copy = addr + crbu_pkg::LINK_STEP;
				if (ctr_ok && cond_ok) begin
					res.taken = 1'b1;
					res.target = dest;
				end
			end
			crbu_pkg::MODE_LOAD_CR: cr_copy = lval;
			crbu_pkg::MODE_LOAD_CTR: ctr_copy = lval;
			crbu_pkg::MODE_LOAD_LR: lr_copy = lval;
			default: ;
		endcase
		res.cr = cr_copy;
		res.ctr = ctr_copy;
		res.lr = lr_copy;
	endtask

	task automatic report_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t predicted;
		outcome_t oldest;
		if (!arst_n) begin
			cr_copy = '0;
			ctr_copy = '0;
			lr_copy = '0;
			outcome_q.delete();
			fail_count = 0;
			outstanding = 0;
			checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result transfer, expected none actual %h",
						$time, {taken, target, cond_reg, count_reg, link_reg});
					fail_count++;
				end else begin
					oldest = outcome_q.pop_front();
					report_field("taken", {31'd0, oldest.taken}, {31'd0, taken});
					report_field("target", oldest.target, target);
					report_field("cond_reg", oldest.cr, cond_reg);
					report_field("count_reg", oldest.ctr, count_reg);
					report_field("link_reg", oldest.lr, link_reg);
					checked++;
				end
			end
			if (in_valid && !in_stall) begin
				apply_operation(mode, insn_word, insn_address, load_value, predicted);
				outcome_q.push_back(predicted);
			end
			outstanding = outcome_q.size();
		end
	end

endmodule

[verif/tb_top.sv]
// tb_top: drives directed and random operations into the cr logic and branch unit with
// random gaps and output stalls, and gives the verdict from the checker's failure count or a timeout
// depends on crbu_pkg, cr_logic_and_branch_condition_unit and crbu_result_checker
`timescale 1ns / 1ps

module tb_top;

	localparam logic [3:0] MODE_UNDEF_LO = 4'd9;
	localparam logic [3:0] MODE_UNDEF_HI = 4'd15;
	localparam int RANDOM_ITEMS = 450;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        out_stall;
	logic [3:0]  mode;
	logic [31:0] insn_word;
	logic [31:0] insn_address;
	logic [31:0] load_value;
	wire         in_stall;
	wire         out_valid;
	wire         taken;
	wire  [31:0] target;
	wire  [31:0] cond_reg;
	wire  [31:0] count_reg;
	wire  [31:0] link_reg;
	int          fail_count;
	int          outstanding;
	int          checked;
	int          sent;
	int          cycles;
	logic        no_idle;

	cr_logic_and_branch_condition_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .insn_word(insn_word), .insn_address(insn_address),
		.load_value(load_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.taken(taken), .target(target), .cond_reg(cond_reg),
		.count_reg(count_reg), .link_reg(link_reg)
	);

	crbu_result_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .insn_word(insn_word), .insn_address(insn_address),
		.load_value(load_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.taken(taken), .target(target), .cond_reg(cond_reg),
		.count_reg(count_reg), .link_reg(link_reg),
		.fail_count(fail_count), .outstanding(outstanding), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [31:0] form_insn(logic [4:0] d, logic [4:0] a, logic [4:0] b,
			logic lk);
		logic [31:0] r;
		r = $urandom;
		return {r[31:26], d, a, b, r[10:1], lk};
	endfunction

	task automatic send_op(input logic [3:0] op, input logic [31:0] insn,
			input logic [31:0] addr, input logic [31:0] lval);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		insn_word <= insn;
		insn_address <= addr;
		load_value <= lval;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	// output side, with one long hold-off so the unit fills and stalls its input
	initial begin
		int wait_cycles;
		int received;
		logic held;
		received = 0;
		held = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (received == 200 && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				wait_cycles = no_idle ? 0 : $urandom_range(0, 10);
				if (wait_cycles != 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			received++;
			@(negedge clk);
		end
	end

	initial begin
		logic [3:0]  op;
		logic [31:0] lval;
		int          pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		mode = '0;
		insn_word = '0;
		insn_address = '0;
		load_value = '0;
		sent = 0;
		cycles = 0;
		no_idle = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_op(crbu_pkg::MODE_LOAD_CR, $urandom, $urandom, 32'hffff_ffff);
		send_op(crbu_pkg::MODE_LOAD_CTR, $urandom, $urandom, 32'h0000_0000);
		send_op(crbu_pkg::MODE_LOAD_LR, $urandom, $urandom, 32'hffff_ffff);
		send_op(crbu_pkg::MODE_CRXOR, form_insn(5'd0, 5'd31, 5'd0, 1'b1),
			$urandom, $urandom);
		send_op(crbu_pkg::MODE_CRNOR, form_insn(5'd31, 5'd0, 5'd0, 1'b0),
			$urandom, $urandom);
		send_op(crbu_pkg::MODE_CROR, form_insn(5'd16, 5'd0, 5'd31, 1'b1),
			$urandom, $urandom);
		send_op(crbu_pkg::MODE_LOAD_CR, $urandom, $urandom, 32'h0000_000f);
		send_op(crbu_pkg::MODE_MCRF, form_insn(5'd0, 5'd28, 5'd31, 1'b1),
			$urandom, $urandom);
		send_op(crbu_pkg::MODE_MCRF, form_insn(5'd31, 5'd3, 5'd0, 1'b0),
			$urandom, $urandom);
		// decrement through zero, wrapping link value
		send_op(crbu_pkg::MODE_BCLR, form_insn(5'b00000, 5'd1, 5'd31, 1'b1),
			32'hffff_fffc, $urandom);
		send_op(crbu_pkg::MODE_BCLR, form_insn(5'b10100, 5'd0, 5'd0, 1'b0),
			$urandom, $urandom);
		send_op(crbu_pkg::MODE_LOAD_CTR, $urandom, $urandom, 32'h0000_0001);
		send_op(crbu_pkg::MODE_BCLR, form_insn(5'b10010, 5'd0, 5'd0, 1'b1),
			32'h0000_0000, $urandom);
		send_op(crbu_pkg::MODE_BCCTR, form_insn(5'b10100, 5'd7, 5'd0, 1'b1),
			32'h0000_0000, $urandom);
		send_op(crbu_pkg::MODE_LOAD_CTR, $urandom, $urandom, 32'hffff_ffff);
		send_op(crbu_pkg::MODE_BCCTR, form_insn(5'b01100, 5'd0, 5'd0, 1'b0),
			$urandom, $urandom);
		send_op(crbu_pkg::MODE_BCCTR, form_insn(5'b00100, 5'd0, 5'd0, 1'b1),
			$urandom, $urandom);
		send_op(MODE_UNDEF_LO, 32'hffff_ffff, $urandom, $urandom);
		send_op(MODE_UNDEF_HI, 32'hffff_ffff, $urandom, 32'hffff_ffff);
		send_op(crbu_pkg::MODE_LOAD_LR, $urandom, $urandom, 32'h0000_0003);
		send_op(crbu_pkg::MODE_BCLR, form_insn(5'b10100, 5'd0, 5'd0, 1'b1),
			32'hffff_ffff, $urandom);
		send_op(crbu_pkg::MODE_LOAD_CR, $urandom, $urandom, 32'h0000_0000);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_idle = ((i / 50) % 3) == 1;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				op = 4'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
			else
				op = 4'($urandom_range(crbu_pkg::MODE_CROR, crbu_pkg::MODE_LOAD_LR));
			lval = $urandom;
			if (op == crbu_pkg::MODE_LOAD_CTR && $urandom_range(0, 1))
				lval = $urandom_range(0, 3);
			send_op(op, $urandom, $urandom, lval);
		end
		in_valid <= 1'b0;
		no_idle = 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("covered %0d transfers in, %0d results checked: all operations and undefined",
			sent, checked);
		$display("codes, with random gaps on both sides, idle-free bursts and a long hold-off");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
